[rtl/srrr_pkg.sv]
// shared types and constants for the selective-repeat reorder receiver
package srrr_pkg;

  localparam int SEQ_W = 32;
  localparam int LEN_W = 11;
  localparam int DEF_WINDOW = 16;
  localparam int DEF_MAX_PAYLOAD = 1500;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    KIND_RELEASE = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_FINACK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_FIN,
    ST_DRAIN_CHK,
    ST_DRAIN_REL,
    ST_ACK
  } state_t;

endpackage

[rtl/srrr_ram.sv]
// generic single-write single-read ram with registered read
module srrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/srrr_slots.sv]
// per-slot present flags with set, clear and two lookups
module srrr_slots import srrr_pkg::*; #(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      set_en,
  input  logic [$clog2(WINDOW)-1:0] set_idx,
  input  logic                      clr_en,
  input  logic [$clog2(WINDOW)-1:0] clr_idx,
  input  logic [$clog2(WINDOW)-1:0] rd_a_idx,
  output logic                      rd_a,
  input  logic [$clog2(WINDOW)-1:0] rd_b_idx,
  output logic                      rd_b
);

  logic [WINDOW-1:0] present;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else begin
      if (set_en) begin
        present[set_idx] <= 1'b1;
      end
      if (clr_en) begin
        present[clr_idx] <= 1'b0;
      end
    end
  end

  assign rd_a = present[rd_a_idx];
  assign rd_b = present[rd_b_idx];

endmodule

[rtl/selective_repeat_reorder_receiver.sv]
// top level: header sequencer, slot flags and length ram of the reorder receiver
//
// channel  dir  tdata (low bit up)                                   tuser  tlast
// s_axis   in   seq_num[31:0] payload_length[42:32] zero pad         mode   -
// m_axis   out  release_seq[31:0] release_length[42:32]              kind   last
//               ack_number[74:43] zero pad
//
// early, old or duplicate header: accept, decide, ack; in-order header: accept, decide,
// drain check and drain release per drained slot (the length ram read is registered),
// a last drain check and ack; fin: accept, fin; a header while closed: accept only
// reset clears expected sequence, present flags and closed; lengths need no clearing
// output stalls hold the sequencer in place; input is taken only while idle
module selective_repeat_reorder_receiver import srrr_pkg::*; #(
  parameter int WINDOW = DEF_WINDOW,
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // seq_num, payload_length
  input  logic                  s_axis_tuser,  // mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // release_seq, release_length, ack_number
  output logic [1:0]            m_axis_tuser,  // kind
  output logic                  m_axis_tlast
);

  localparam int SW = $clog2(WINDOW);
  localparam int GW = $clog2(WINDOW + 1);

  state_t state, state_next;

  logic [SEQ_W-1:0] expected, expected_next;
  logic [SW-1:0]    exp_slot, exp_slot_next;
  logic [GW-1:0]    guard, guard_next;
  logic             closed, closed_next;

  logic [SEQ_W-1:0] in_seq;
  logic [LEN_W-1:0] in_len;
  logic [LEN_W-1:0] len_sat;

  logic             out_valid, out_valid_next;
  kind_t            out_kind;
  logic [SEQ_W-1:0] out_seq;
  logic [LEN_W-1:0] out_len;
  logic [SEQ_W-1:0] out_ack;
  logic             out_last;

  logic             emit;
  kind_t            emit_kind;
  logic [SEQ_W-1:0] emit_seq;
  logic [LEN_W-1:0] emit_len;
  logic [SEQ_W-1:0] emit_ack;
  logic             emit_last;

  logic             out_free;
  logic             in_acc;

  logic [SEQ_W-1:0] seq_delta;
  logic [SW:0]      slot_sum;
  logic [SW-1:0]    early_slot;
  logic             early_present;
  logic             exp_present;
  logic [SW-1:0]    slot_adv;

  logic             set_en;
  logic             clr_en;
  logic             ram_re;
  logic [LEN_W-1:0] ram_rdata;

  assign out_free = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign len_sat = (s_axis_tdata[42:32] > LEN_W'(MAX_PAYLOAD)) ?
                   LEN_W'(MAX_PAYLOAD) : s_axis_tdata[42:32];

  assign seq_delta = in_seq - expected;
  assign slot_sum = {1'b0, exp_slot} + {1'b0, seq_delta[SW-1:0]};

  always_comb begin
    if (in_seq < seq_delta) begin
      early_slot = in_seq[SW-1:0];
    end else if (slot_sum >= (SW+1)'(WINDOW)) begin
      early_slot = SW'(slot_sum - (SW+1)'(WINDOW));
    end else begin
      early_slot = slot_sum[SW-1:0];
    end
  end

  assign slot_adv = ((expected == '1) || (exp_slot == SW'(WINDOW - 1))) ?
                    '0 : exp_slot + SW'(1);

  srrr_slots #(
    .WINDOW(WINDOW)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .set_en   (set_en),
    .set_idx  (early_slot),
    .clr_en   (clr_en),
    .clr_idx  (exp_slot),
    .rd_a_idx (early_slot),
    .rd_a     (early_present),
    .rd_b_idx (exp_slot),
    .rd_b     (exp_present)
  );

  srrr_ram #(
    .WIDTH(LEN_W),
    .DEPTH(WINDOW)
  ) u_len_ram (
    .clk   (clk),
    .we    (set_en),
    .waddr (early_slot),
    .wdata (in_len),
    .re    (ram_re),
    .raddr (exp_slot),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next    = state;
    expected_next = expected;
    exp_slot_next = exp_slot;
    guard_next    = guard;
    closed_next   = closed;
    emit          = 1'b0;
    emit_kind     = KIND_ACK;
    emit_seq      = '0;
    emit_len      = '0;
    emit_ack      = '0;
    emit_last     = 1'b0;
    set_en        = 1'b0;
    clr_en        = 1'b0;
    ram_re        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_acc && !closed) begin
          state_next = s_axis_tuser ? ST_FIN : ST_DECIDE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_kind   = KIND_FINACK;
          emit_ack    = expected;
          emit_last   = 1'b1;
          closed_next = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_DECIDE: begin
        if (seq_delta == '0) begin
          if (out_free) begin
            emit          = 1'b1;
            emit_kind     = KIND_RELEASE;
            emit_seq      = in_seq;
            emit_len      = in_len;
            clr_en        = 1'b1;
            expected_next = expected + SEQ_W'(1);
            exp_slot_next = slot_adv;
            guard_next    = GW'(1);
            state_next    = ST_DRAIN_CHK;
          end
        end else begin
          if ((seq_delta < SEQ_W'(WINDOW)) && !early_present) begin
            set_en = 1'b1;
          end
          state_next = ST_ACK;
        end
      end
      ST_DRAIN_CHK: begin
        if ((guard < GW'(WINDOW)) && exp_present) begin
          ram_re     = 1'b1;
          state_next = ST_DRAIN_REL;
        end else begin
          state_next = ST_ACK;
        end
      end
      ST_DRAIN_REL: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_kind     = KIND_RELEASE;
          emit_seq      = expected;
          emit_len      = ram_rdata;
          clr_en        = 1'b1;
          expected_next = expected + SEQ_W'(1);
          exp_slot_next = slot_adv;
          guard_next    = guard + GW'(1);
          state_next    = ST_DRAIN_CHK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_ACK;
          emit_ack   = expected;
          emit_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = emit || (out_valid && !m_axis_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      expected  <= '0;
      exp_slot  <= '0;
      guard     <= '0;
      closed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      expected  <= expected_next;
      exp_slot  <= exp_slot_next;
      guard     <= guard_next;
      closed    <= closed_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_seq  <= s_axis_tdata[31:0];
      in_len  <= len_sat;
    end
    if (emit) begin
      out_kind <= emit_kind;
      out_seq  <= emit_seq;
      out_len  <= emit_len;
      out_ack  <= emit_ack;
      out_last <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - 2*SEQ_W - LEN_W){1'b0}}, out_ack, out_len, out_seq};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

[tb/sv/selective_repeat_reorder_receiver_tb.sv]
// testbench for the selective-repeat reorder receiver: packet header stimulus with self-checking
`timescale 1ns / 100ps

module selective_repeat_reorder_receiver_tb;
  import srrr_pkg::*;

  localparam int WIN  = DEF_WINDOW;
  localparam int MAXP = DEF_MAX_PAYLOAD;

  typedef struct {
    logic        mode;
    logic [31:0] seq;
    logic [10:0] len;
  } hdr_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] rseq;
    logic [10:0] rlen;
    logic [31:0] ackn;
    logic        lastf;
  } resp_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  hdr_t  hdr_q[$];
  resp_t resp_q[$];
  hdr_t  cur_hdr;
  int    send_gap = 0;
  int    rcv_gap = 0;
  bit    steady = 1'b0;
  int    hdr_sent = 0;
  int    hdr_taken = 0;
  int    err_cnt = 0;
  int    rel_seen = 0;
  int    ack_seen = 0;
  int    longest_drain = 0;

  // receiver state as predicted
  logic [31:0] nxt_seq = '0;
  logic        held [0:WIN-1];
  logic [10:0] held_len [0:WIN-1];
  logic        shut = 1'b0;

  selective_repeat_reorder_receiver i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic resp_t make_resp(kind_t kind, logic [31:0] rseq, logic [10:0] rlen,
                                      logic [31:0] ackn, logic lastf);
    resp_t r;
    r.kind = kind;
    r.rseq = rseq;
    r.rlen = rlen;
    r.ackn = ackn;
    r.lastf = lastf;
    return r;
  endfunction

  task automatic predict_header(input hdr_t h);
    logic [31:0] delta;
    logic [10:0] len;
    int          rels;
    if (shut) return;
    if (h.mode) begin
      resp_q.push_back(make_resp(KIND_FINACK, '0, '0, nxt_seq, 1'b1));
      shut = 1'b1;
      return;
    end
    len = (h.len > MAXP) ? 11'(MAXP) : h.len;
    delta = h.seq - nxt_seq;
    if (delta == 0) begin
      held[h.seq % WIN] = 1'b0;
      resp_q.push_back(make_resp(KIND_RELEASE, h.seq, len, '0, 1'b0));
      nxt_seq = nxt_seq + 1;
      rels = 1;
      for (int g = 1; g < WIN; g++) begin
        if (!held[nxt_seq % WIN]) break;
        resp_q.push_back(make_resp(KIND_RELEASE, nxt_seq, held_len[nxt_seq % WIN], '0, 1'b0));
        held[nxt_seq % WIN] = 1'b0;
        nxt_seq = nxt_seq + 1;
        rels++;
      end
      if (rels > longest_drain) longest_drain = rels;
    end else if (delta < WIN) begin
      if (!held[h.seq % WIN]) begin
        held[h.seq % WIN] = 1'b1;
        held_len[h.seq % WIN] = len;
      end
    end
    resp_q.push_back(make_resp(KIND_ACK, '0, '0, nxt_seq, 1'b1));
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_header(cur_hdr);
        hdr_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (hdr_q.size() != 0) begin
          cur_hdr = hdr_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'b0, cur_hdr.len, cur_hdr.seq};
          s_axis_tuser <= cur_hdr.mode;
          send_gap <= rand_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rcv_gap <= 0;
    end else begin
      if (rcv_gap != 0) begin
        rcv_gap <= rcv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rcv_gap <= rand_gap();
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (resp_q.size() == 0) begin
          report("unexpected word, ack field", m_axis_tdata[74:43], '0);
        end else begin
          want = resp_q.pop_front();
          if (want.kind == KIND_RELEASE) rel_seen++;
          else ack_seen++;
          if (m_axis_tuser !== want.kind) report("kind", 32'(m_axis_tuser), 32'(want.kind));
          if (m_axis_tdata[31:0] !== want.rseq)
            report("release_seq", m_axis_tdata[31:0], want.rseq);
          if (m_axis_tdata[42:32] !== want.rlen)
            report("release_length", 32'(m_axis_tdata[42:32]), 32'(want.rlen));
          if (m_axis_tdata[74:43] !== want.ackn)
            report("ack_number", m_axis_tdata[74:43], want.ackn);
          if (m_axis_tlast !== want.lastf)
            report("last", 32'(m_axis_tlast), 32'(want.lastf));
        end
      end
    end
  end

  task automatic push_hdr(input logic mode, input logic [31:0] seq, input logic [10:0] len);
    hdr_t h;
    h.mode = mode;
    h.seq = seq;
    h.len = len;
    hdr_q.push_back(h);
    hdr_sent++;
  endtask

  task automatic wait_taken();
    while (hdr_taken != hdr_sent) @(negedge clk);
  endtask

  task automatic wait_quiet();
    wait_taken();
    while (resp_q.size() != 0) @(negedge clk);
  endtask

  // in-window burst from the next expected number, shuffled, with holes and repeats
  task automatic send_burst(input int k, input int keep_pct, input int dups);
    logic [31:0] order [0:39];
    logic [31:0] base;
    logic [31:0] tmp;
    int          n;
    int          j;
    wait_taken();
    base = nxt_seq;
    n = 0;
    for (int i = 0; i < k; i++) begin
      if ($urandom_range(0, 99) < keep_pct) begin
        order[n] = base + i;
        n++;
      end
    end
    for (int i = 0; i < dups && n > 0; i++) begin
      order[n] = order[$urandom_range(0, n - 1)];
      n++;
    end
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < n; i++) push_hdr(1'b0, order[i], 11'($urandom_range(0, 2047)));
  endtask

  initial begin
    int pick;
    for (int i = 0; i < WIN; i++) begin
      held[i] = 1'b0;
      held_len[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: in order, saturation, old, window edge, duplicate, full window drain
    push_hdr(1'b0, 32'd0, 11'd0);
    push_hdr(1'b0, 32'd1, 11'd2047);
    push_hdr(1'b0, 32'd1, 11'd5);
    push_hdr(1'b0, 32'd2 + WIN, 11'd100);
    push_hdr(1'b0, 32'd17, 11'd1500);
    push_hdr(1'b0, 32'd17, 11'd7);
    push_hdr(1'b0, 32'hFFFF_FFFF, 11'd1);
    push_hdr(1'b0, 32'h8000_0000, 11'd1024);
    for (int s = 3; s <= 16; s++)
      push_hdr(1'b0, 32'(s), (s == 5) ? 11'd1501 : (s == 6) ? 11'd0 : 11'(s * 100));
    push_hdr(1'b0, 32'd2, 11'd42);
    wait_quiet();

    while (hdr_sent < 150) begin
      pick = $urandom_range(0, 9);
      steady = ($urandom_range(0, 4) == 0);
      if (pick <= 5) begin
        send_burst($urandom_range(1, WIN), 100, $urandom_range(0, 2));
      end else if (pick <= 7) begin
        send_burst($urandom_range(2, WIN), 70, $urandom_range(0, 3));
      end else if (pick == 8) begin
        wait_taken();
        push_hdr(1'b0, $urandom, 11'($urandom_range(0, 2047)));
        push_hdr(1'b0, nxt_seq - $urandom_range(1, 20), 11'($urandom_range(0, 2047)));
        push_hdr(1'b0, nxt_seq + $urandom_range(WIN, 100), 11'($urandom_range(0, 2047)));
        push_hdr(1'b0, nxt_seq + WIN, 11'($urandom_range(0, 2047)));
      end else begin
        wait_quiet();
      end
    end

    // close, then headers that must be ignored
    steady = 1'b0;
    wait_taken();
    push_hdr(1'b1, $urandom, 11'($urandom_range(0, 2047)));
    push_hdr(1'b0, nxt_seq, 11'd10);
    push_hdr(1'b0, nxt_seq + 1, 11'd20);
    push_hdr(1'b1, $urandom, 11'd0);
    push_hdr(1'b0, $urandom, 11'd2047);
    wait_quiet();
    repeat (60) @(negedge clk);

    $display("headers sent %0d: %0d releases and %0d acks/finacks checked, longest drain %0d",
             hdr_sent, rel_seen, ack_seen, longest_drain);
    $display("window drains, duplicates, drops, length saturation, fin and closed headers");
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d words outstanding", resp_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
